// ===== design/lvm_pkg.sv =====
package lvm_pkg;

  // square root steps for a 64 bit radicand
  localparam int SQRT_STEPS = 32;

  localparam logic [31:0] TOP31 = 32'h8000_0000;

  // word carried alongside the square root and divider stages
  typedef struct packed {
    logic             ok;
    logic [2:0]       sgn;
    logic [2:0][31:0] mag;
  } ucar_t;

  // latency of the unit vector pipeline for fb fractional bits
  function automatic int unit_lat(input int fb);
    return 9 + SQRT_STEPS + fb;
  endfunction

endpackage

// ===== design/lvm_unit.sv =====
module lvm_unit #(
  parameter int IW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [IW-1:0] v_i [3],
  output logic                 vld_o,
  output logic                 ok_o,
  output logic signed [FB+1:0] u_o [3]
);
  import lvm_pkg::*;

  localparam int PW = $clog2(IW);
  localparam int Q  = FB + 2;
  localparam int NW = 33 + FB;
  localparam int ST = SQRT_STEPS;

  // stage 1: sign and magnitude, largest magnitude
  logic [IW-1:0] mag_nxt [3];
  logic [IW-1:0] max_nxt;
  logic [IW-1:0] mag1_r [3];
  logic [IW-1:0] max1_r;
  logic [2:0]    sgn1_r;
  logic          vld1_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag_nxt[c] = v_i[c][IW-1] ? IW'(-v_i[c]) : IW'(v_i[c]);
    end
    max_nxt = mag_nxt[0];
    if (mag_nxt[1] > max_nxt) max_nxt = mag_nxt[1];
    if (mag_nxt[2] > max_nxt) max_nxt = mag_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        mag1_r[c] <= mag_nxt[c];
        sgn1_r[c] <= v_i[c][IW-1];
      end
      max1_r <= max_nxt;
    end
  end

  // stage 2: leading one of the largest magnitude
  logic [PW-1:0] p_nxt;
  logic [PW-1:0] p2_r;
  logic [IW-1:0] mag2_r [3];
  logic [IW-1:0] max2_r;
  logic [2:0]    sgn2_r;
  logic          ok2_r;
  logic          vld2_r;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < IW; i++) begin
      if (max1_r[i]) p_nxt = PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r   <= p_nxt;
      mag2_r <= mag1_r;
      max2_r <= max1_r;
      sgn2_r <= sgn1_r;
      ok2_r  <= |max1_r;
    end
  end

  // stage 3: align so the largest lies in (2^30, 2^31]
  logic [IW+30:0] wide_nxt [3];
  logic [IW+30:0] wmax_nxt;
  logic [31:0]    um_nxt;
  ucar_t          car3_nxt;
  ucar_t          car3_r;
  logic           vld3_r;

  always_comb begin
    wmax_nxt = {max2_r, 31'b0} >> p2_r;
    um_nxt   = wmax_nxt[31:0];
    car3_nxt.ok  = ok2_r;
    car3_nxt.sgn = sgn2_r;
    for (int c = 0; c < 3; c++) begin
      wide_nxt[c] = {mag2_r[c], 31'b0} >> p2_r;
      if (um_nxt == TOP31) begin
        car3_nxt.mag[c] = wide_nxt[c][31:0];
      end else if (um_nxt == TOP31 + 32'd1) begin
        car3_nxt.mag[c] = {wide_nxt[c][31:1], 1'b0};
      end else begin
        car3_nxt.mag[c] = {1'b0, wide_nxt[c][31:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) car3_r <= car3_nxt;
  end

  // stage 4: squares, stage 5: sum
  logic [63:0] sq4_r [3];
  ucar_t       car4_r;
  logic        vld4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq4_r[c] <= 64'(car3_r.mag[c]) * 64'(car3_r.mag[c]);
      end
      car4_r <= car3_r;
    end
  end

  // square root, one bit per stage
  logic [63:0] x_s_r   [ST+1];
  logic [63:0] res_s_r [ST+1];
  ucar_t       car_s_r [ST+1];
  logic        vld_s_r [ST+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_s_r[0]   <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      res_s_r[0] <= '0;
      car_s_r[0] <= car4_r;
    end
  end

  for (genvar k = 0; k < ST; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
    logic [63:0] t_nxt;
    assign t_nxt = res_s_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (x_s_r[k] >= t_nxt) begin
          x_s_r[k+1]   <= x_s_r[k] - t_nxt;
          res_s_r[k+1] <= (res_s_r[k] >> 1) + BIT;
        end else begin
          x_s_r[k+1]   <= x_s_r[k];
          res_s_r[k+1] <= res_s_r[k] >> 1;
        end
        car_s_r[k+1] <= car_s_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_s_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_s_r[k+1] <= vld_s_r[k];
      end
    end
  end

  // divider: rounded numerator, then one quotient bit per stage
  logic [31:0]  len_nxt;
  logic [NW-1:0] num_nxt [3];
  logic [31:0]  len_d_r [Q+1];
  logic [31:0]  rem_d_r [Q+1][3];
  logic [Q-1:0] ql_d_r  [Q+1][3];
  ucar_t        car_d_r [Q+1];
  logic         vld_d_r [Q+1];

  always_comb begin
    len_nxt = res_s_r[ST][31:0];
    for (int c = 0; c < 3; c++) begin
      num_nxt[c] = NW'({car_s_r[ST].mag[c], {FB{1'b0}}}) + NW'(len_nxt[31:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_d_r[0] <= len_nxt;
      car_d_r[0] <= car_s_r[ST];
      for (int c = 0; c < 3; c++) begin
        rem_d_r[0][c] <= 32'(num_nxt[c][NW-1:Q]);
        ql_d_r[0][c]  <= num_nxt[c][Q-1:0];
      end
    end
  end

  for (genvar j = 0; j < Q; j++) begin : g_div
    logic [32:0] t_nxt [3];
    logic [2:0]  ge_nxt;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        t_nxt[c]  = {rem_d_r[j][c], ql_d_r[j][c][Q-1]};
        ge_nxt[c] = t_nxt[c] >= {1'b0, len_d_r[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          rem_d_r[j+1][c] <= ge_nxt[c] ? 32'(t_nxt[c] - {1'b0, len_d_r[j]})
                                       : t_nxt[c][31:0];
          ql_d_r[j+1][c]  <= {ql_d_r[j][c][Q-2:0], ge_nxt[c]};
        end
        len_d_r[j+1] <= len_d_r[j];
        car_d_r[j+1] <= car_d_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_d_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_d_r[j+1] <= vld_d_r[j];
      end
    end
  end

  // sign back on
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        u_o[c] <= car_d_r[Q].sgn[c] ? -$signed(ql_d_r[Q][c]) : $signed(ql_d_r[Q][c]);
      end
      ok_o <= car_d_r[Q].ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r     <= 1'b0;
      vld2_r     <= 1'b0;
      vld3_r     <= 1'b0;
      vld4_r     <= 1'b0;
      vld_s_r[0] <= 1'b0;
      vld_d_r[0] <= 1'b0;
      vld_o      <= 1'b0;
    end else if (en) begin
      vld1_r     <= vld_i;
      vld2_r     <= vld1_r;
      vld3_r     <= vld2_r;
      vld4_r     <= vld3_r;
      vld_s_r[0] <= vld4_r;
      vld_d_r[0] <= vld_s_r[ST];
      vld_o      <= vld_d_r[Q];
    end
  end

endmodule

// ===== design/look_at_view_matrix.sv =====
// throughput: one word per cycle while no held result stalls the pipeline,
// set by a fully pipelined datapath with no shared unit
// the unit vector pipelines (32 square root stages, FRAC_BITS + 2 divider stages) set the depth
// a stalled result freezes the whole pipeline in place, nothing is dropped or repeated
// reset (synchronous, active low) clears every valid bit; data registers are not reset
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_tgt_x,
  input  logic signed [31:0] in_tgt_y,
  input  logic signed [31:0] in_tgt_z,
  input  logic signed [31:0] in_upv_x,
  input  logic signed [31:0] in_upv_y,
  input  logic signed [31:0] in_upv_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_right_x,
  output logic signed [17:0] out_right_y,
  output logic signed [17:0] out_right_z,
  output logic signed [17:0] out_upax_x,
  output logic signed [17:0] out_upax_y,
  output logic signed [17:0] out_upax_z,
  output logic signed [17:0] out_back_x,
  output logic signed [17:0] out_back_y,
  output logic signed [17:0] out_back_z,
  output logic signed [33:0] out_move_x,
  output logic signed [33:0] out_move_y,
  output logic signed [33:0] out_move_z
);
  import lvm_pkg::*;

  localparam int UW = FRAC_BITS + 2;        // unit vector component
  localparam int PW = 2 * UW;               // product of two components
  localparam int YW = PW + 1;               // cross product component
  localparam int DW = UW + 34;              // dot product with a position
  localparam int MW = DW - FRAC_BITS;       // rounded dot magnitude
  localparam int L  = unit_lat(FRAC_BITS);  // unit vector pipeline depth

  localparam logic [YW-1:0] HALF_Y = YW'(1) << (FRAC_BITS - 1);
  localparam logic [YW-1:0] ONE_Y  = YW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] HALF_D = DW'(1) << (FRAC_BITS - 1);
  localparam logic [MW-1:0] POS_LIM = MW'(34'h1_FFFF_FFFF);
  localparam logic [MW-1:0] NEG_LIM = MW'(34'h2_0000_0000);

  // the whole pipeline moves unless a finished word is held at the output
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------------------------------------------------------
  // stage 0: saturating position minus target
  // ---------------------------------------------------------------
  logic signed [31:0] pos_in [3];
  logic signed [31:0] tgt_in [3];
  logic signed [31:0] dif_nxt [3];
  logic signed [31:0] dif0_r [3];
  logic signed [31:0] upv0_r [3];
  logic [2:0][31:0]   pos0_r;
  logic               vld0_r;

  assign pos_in = '{in_pos_x, in_pos_y, in_pos_z};
  assign tgt_in = '{in_tgt_x, in_tgt_y, in_tgt_z};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [32:0] d;
      d = {pos_in[c][31], pos_in[c]} - {tgt_in[c][31], tgt_in[c]};
      if (d[32] != d[31]) begin
        dif_nxt[c] = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        dif_nxt[c] = $signed(d[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dif0_r <= dif_nxt;
      upv0_r <= '{in_upv_x, in_upv_y, in_upv_z};
      for (int c = 0; c < 3; c++) pos0_r[c] <= pos_in[c];
    end
  end

  // ---------------------------------------------------------------
  // back = unit(P - T) and unit(U), side by side
  // ---------------------------------------------------------------
  logic                 vld_b, vld_u, ok_b, ok_u;
  logic signed [UW-1:0] back_u [3];
  logic signed [UW-1:0] nup_u  [3];

  lvm_unit #(.IW(32), .FB(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(vld0_r),
    .v_i(dif0_r), .vld_o(vld_b), .ok_o(ok_b), .u_o(back_u)
  );

  lvm_unit #(.IW(32), .FB(FRAC_BITS)) u_nup (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(vld0_r),
    .v_i(upv0_r), .vld_o(vld_u), .ok_o(ok_u), .u_o(nup_u)
  );

  // position travels beside the unit pipelines
  logic [2:0][31:0] pos_dl_r [L];

  always_ff @(posedge clk) begin
    if (en) begin
      pos_dl_r[0] <= pos0_r;
      for (int i = 1; i < L; i++) pos_dl_r[i] <= pos_dl_r[i-1];
    end
  end

  // ---------------------------------------------------------------
  // stages 1-2: rw = cross(unit(U), back), full precision
  // ---------------------------------------------------------------
  logic signed [PW-1:0] pr1_r [6];
  logic signed [UW-1:0] back1_r [3];
  logic [2:0][31:0]     pos1_r;
  logic                 ok1_r, vld1_r;
  logic signed [YW-1:0] rw2_r [3];
  logic signed [UW-1:0] back2_r [3];
  logic [2:0][31:0]     pos2_r;
  logic                 ok2_r, vld2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pr1_r[0] <= nup_u[1] * back_u[2];
      pr1_r[1] <= nup_u[2] * back_u[1];
      pr1_r[2] <= nup_u[2] * back_u[0];
      pr1_r[3] <= nup_u[0] * back_u[2];
      pr1_r[4] <= nup_u[0] * back_u[1];
      pr1_r[5] <= nup_u[1] * back_u[0];
      back1_r  <= back_u;
      pos1_r   <= pos_dl_r[L-1];
      ok1_r    <= ok_b && ok_u;
      for (int c = 0; c < 3; c++) begin
        rw2_r[c] <= YW'(pr1_r[2*c]) - YW'(pr1_r[2*c+1]);
      end
      back2_r <= back1_r;
      pos2_r  <= pos1_r;
      ok2_r   <= ok1_r;
    end
  end

  // ---------------------------------------------------------------
  // right = unit(rw)
  // ---------------------------------------------------------------
  logic                 vld_r, ok_r;
  logic signed [UW-1:0] right_u [3];

  lvm_unit #(.IW(YW), .FB(FRAC_BITS)) u_right (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(vld2_r),
    .v_i(rw2_r), .vld_o(vld_r), .ok_o(ok_r), .u_o(right_u)
  );

  logic signed [UW-1:0] bk_dl_r  [L][3];
  logic [2:0][31:0]     pos2_dl_r [L];
  logic                 ok_dl_r  [L];

  always_ff @(posedge clk) begin
    if (en) begin
      bk_dl_r[0]   <= back2_r;
      pos2_dl_r[0] <= pos2_r;
      ok_dl_r[0]   <= ok2_r;
      for (int i = 1; i < L; i++) begin
        bk_dl_r[i]   <= bk_dl_r[i-1];
        pos2_dl_r[i] <= pos2_dl_r[i-1];
        ok_dl_r[i]   <= ok_dl_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // stages 3-5: true up = cross(back, right), rounded and clamped
  // ---------------------------------------------------------------
  logic signed [PW-1:0] pr3_r [6];
  logic signed [UW-1:0] right3_r [3], back3_r [3];
  logic [2:0][31:0]     pos3_r;
  logic                 ok3_r, vld3_r;
  logic signed [YW-1:0] yw4_r [3];
  logic signed [UW-1:0] right4_r [3], back4_r [3];
  logic [2:0][31:0]     pos4_r;
  logic                 ok4_r, vld4_r;
  logic signed [UW-1:0] upax_nxt [3];
  logic signed [UW-1:0] upax5_r [3], right5_r [3], back5_r [3];
  logic [2:0][31:0]     pos5_r;
  logic                 ok5_r, vld5_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [YW-1:0] m;
      m = yw4_r[c][YW-1] ? YW'(-yw4_r[c]) : YW'(yw4_r[c]);
      m = (m + HALF_Y) >> FRAC_BITS;
      if (m > ONE_Y) m = ONE_Y;
      upax_nxt[c] = yw4_r[c][YW-1] ? -$signed(UW'(m)) : $signed(UW'(m));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr3_r[0] <= bk_dl_r[L-1][1] * right_u[2];
      pr3_r[1] <= bk_dl_r[L-1][2] * right_u[1];
      pr3_r[2] <= bk_dl_r[L-1][2] * right_u[0];
      pr3_r[3] <= bk_dl_r[L-1][0] * right_u[2];
      pr3_r[4] <= bk_dl_r[L-1][0] * right_u[1];
      pr3_r[5] <= bk_dl_r[L-1][1] * right_u[0];
      right3_r <= right_u;
      back3_r  <= bk_dl_r[L-1];
      pos3_r   <= pos2_dl_r[L-1];
      ok3_r    <= ok_dl_r[L-1] && ok_r;
      for (int c = 0; c < 3; c++) begin
        yw4_r[c] <= YW'(pr3_r[2*c]) - YW'(pr3_r[2*c+1]);
      end
      right4_r <= right3_r;
      back4_r  <= back3_r;
      pos4_r   <= pos3_r;
      ok4_r    <= ok3_r;
      upax5_r  <= upax_nxt;
      right5_r <= right4_r;
      back5_r  <= back4_r;
      pos5_r   <= pos4_r;
      ok5_r    <= ok4_r;
    end
  end

  // ---------------------------------------------------------------
  // stages 6-8: move = -dot(axis, P), rounded and saturated
  // ---------------------------------------------------------------
  logic signed [UW+31:0] dp6_r [3][3];
  logic signed [UW-1:0]  ax6_r [3][3];
  logic                  ok6_r, vld6_r;
  logic signed [DW-1:0]  d7_r [3];
  logic signed [UW-1:0]  ax7_r [3][3];
  logic                  ok7_r, vld7_r;
  logic signed [33:0]    mv_nxt [3];
  logic signed [17:0]    ax8_r [3][3];
  logic signed [33:0]    mv8_r [3];
  logic                  vld8_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      logic [DW-1:0] m;
      logic [MW-1:0] mr;
      m  = d7_r[r][DW-1] ? DW'(-d7_r[r]) : DW'(d7_r[r]);
      m  = (m + HALF_D) >> FRAC_BITS;
      mr = m[MW-1:0];
      if (d7_r[r][DW-1]) begin
        mv_nxt[r] = (mr > POS_LIM) ? 34'sh1_FFFF_FFFF : $signed(mr[33:0]);
      end else begin
        mv_nxt[r] = (mr > NEG_LIM) ? 34'sh2_0000_0000 : -$signed(mr[33:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax6_r[0] <= right5_r;
      ax6_r[1] <= upax5_r;
      ax6_r[2] <= back5_r;
      for (int c = 0; c < 3; c++) begin
        dp6_r[0][c] <= right5_r[c] * $signed(pos5_r[c]);
        dp6_r[1][c] <= upax5_r[c] * $signed(pos5_r[c]);
        dp6_r[2][c] <= back5_r[c] * $signed(pos5_r[c]);
      end
      ok6_r <= ok5_r;
      for (int r = 0; r < 3; r++) begin
        d7_r[r] <= DW'(dp6_r[r][0]) + DW'(dp6_r[r][1]) + DW'(dp6_r[r][2]);
      end
      ax7_r <= ax6_r;
      ok7_r <= ok6_r;
      // a degenerate basis gives an all-zero word
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          ax8_r[r][c] <= ok7_r ? 18'(ax7_r[r][c]) : '0;
        end
        mv8_r[r] <= ok7_r ? mv_nxt[r] : '0;
      end
    end
  end

  // valid bits, in step with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
      vld8_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
      vld1_r <= vld_b && vld_u;
      vld2_r <= vld1_r;
      vld3_r <= vld_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
      vld8_r <= vld7_r;
    end
  end

  assign out_valid   = vld8_r;
  assign out_right_x = ax8_r[0][0];
  assign out_right_y = ax8_r[0][1];
  assign out_right_z = ax8_r[0][2];
  assign out_upax_x  = ax8_r[1][0];
  assign out_upax_y  = ax8_r[1][1];
  assign out_upax_z  = ax8_r[1][2];
  assign out_back_x  = ax8_r[2][0];
  assign out_back_y  = ax8_r[2][1];
  assign out_back_z  = ax8_r[2][2];
  assign out_move_x  = mv8_r[0];
  assign out_move_y  = mv8_r[1];
  assign out_move_z  = mv8_r[2];

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  // a held result must hold the input side as well
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("held result did not stall the input");

  // a zero back axis only comes from a degenerate basis, which zeroes the word
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_back_x == 0 && out_back_y == 0 && out_back_z == 0) |->
    (out_right_x == 0 && out_right_y == 0 && out_right_z == 0 &&
     out_move_x == 0 && out_move_y == 0 && out_move_z == 0))
    else $error("zero back axis with non-zero result fields");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid straight after reset");

endmodule

// ===== sim/tb_look_at_view_matrix.sv =====
module tb_look_at_view_matrix;

  localparam int FB = 16;
  localparam int LATENCY = 2 * (41 + FB) + 9;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_RANDOM = 1800;

  typedef struct {
    logic signed [31:0] pos[3];
    logic signed [31:0] tgt[3];
    logic signed [31:0] upv[3];
  } camera_t;

  typedef struct {
    logic signed [17:0] axis[9];   // right, true up, back rows
    logic signed [33:0] move[3];
  } view_t;

  // bit-exact view matrix predictor
  class view_predictor;
    view_t pending[$];
    int mismatches;

    function automatic longint round_frac(longint p);
      longint m;
      m = p < 0 ? -p : p;
      m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
      return p < 0 ? -m : m;
    endfunction

    function automatic longint sat(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // normalise; returns 0 for a zero length vector
    function automatic bit unit_vec(input longint v[3], output longint u[3]);
      logic [63:0] mag[3], m, s, len, q;
      for (int i = 0; i < 3; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        u[i] = 0;
      end
      m = mag[0];
      if (mag[1] > m) m = mag[1];
      if (mag[2] > m) m = mag[2];
      if (m == 0) return 0;
      while (m > 64'h8000_0000) begin
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        m = m >> 1;
      end
      while (m <= 64'h4000_0000) begin
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        m = m << 1;
      end
      s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = int_sqrt(s);
      if (len == 0) return 0;
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << FB) + (len >> 1)) / len;
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function void note_camera(camera_t c);
      longint pos[3], dif[3], upv[3], back[3], nup[3], rw[3], right[3];
      longint yw[3], upax[3], d;
      view_t v;
      bit ok;
      for (int i = 0; i < 3; i++) begin
        pos[i] = c.pos[i];
        dif[i] = sat(longint'(c.pos[i]) - longint'(c.tgt[i]),
                     -64'sh8000_0000, 64'sh7fff_ffff);
        upv[i] = c.upv[i];
      end
      for (int i = 0; i < 9; i++) v.axis[i] = 0;
      for (int i = 0; i < 3; i++) v.move[i] = 0;
      ok = unit_vec(dif, back);
      if (ok) ok = unit_vec(upv, nup);
      if (ok) begin
        cross3(nup, back, rw);
        ok = unit_vec(rw, right);
      end
      if (ok) begin
        cross3(back, right, yw);
        for (int i = 0; i < 3; i++)
          upax[i] = sat(round_frac(yw[i]), -(64'sd1 <<< FB), 64'sd1 <<< FB);
        for (int i = 0; i < 3; i++) begin
          v.axis[i] = right[i];
          v.axis[3 + i] = upax[i];
          v.axis[6 + i] = back[i];
        end
        for (int r = 0; r < 3; r++) begin
          d = 0;
          for (int i = 0; i < 3; i++) d += longint'(v.axis[3 * r + i]) * pos[i];
          v.move[r] = sat(-round_frac(d), -(64'sd1 <<< 33), (64'sd1 <<< 33) - 1);
        end
      end
      pending.push_back(v);
    endfunction

    function void check_view(view_t got);
      view_t exp;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
        return;
      end
      exp = pending.pop_front();
      bad = 0;
      for (int i = 0; i < 9; i++) if (got.axis[i] !== exp.axis[i]) bad = 1;
      for (int i = 0; i < 3; i++) if (got.move[i] !== exp.move[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("axis exp %p got %p", exp.axis, got.axis);
          $display("move exp %p got %p", exp.move, got.move);
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z, in_tgt_x, in_tgt_y, in_tgt_z;
  logic signed [31:0] in_upv_x, in_upv_y, in_upv_z;
  logic signed [17:0] out_right_x, out_right_y, out_right_z;
  logic signed [17:0] out_upax_x, out_upax_y, out_upax_z;
  logic signed [17:0] out_back_x, out_back_y, out_back_z;
  logic signed [33:0] out_move_x, out_move_y, out_move_z;

  look_at_view_matrix #(.FRAC_BITS(FB)) dut (.*);

  view_predictor views = new();
  camera_t cams[$];
  bit calm;      // stretch with no idling on either side
  bit sending_done;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // random component with a bias towards the extremes and small values
  function automatic logic signed [31:0] pick();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 0;
      3: return $signed($urandom_range(0, 8)) - 4;
      4, 5: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic camera_t make_cam(logic signed [31:0] p0, p1, p2, t0, t1, t2,
                                       u0, u1, u2);
    camera_t c;
    c.pos = '{p0, p1, p2};
    c.tgt = '{t0, t1, t2};
    c.upv = '{u0, u1, u2};
    return c;
  endfunction

  task automatic send_camera(camera_t c);
    in_pos_x <= c.pos[0]; in_pos_y <= c.pos[1]; in_pos_z <= c.pos[2];
    in_tgt_x <= c.tgt[0]; in_tgt_y <= c.tgt[1]; in_tgt_z <= c.tgt[2];
    in_upv_x <= c.upv[0]; in_upv_y <= c.upv[1]; in_upv_z <= c.upv[2];
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    views.note_camera(c);
    // sender gap after about 19 words in a hundred
    if (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  // result side: stall and check
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        view_t g;
        g.axis = '{out_right_x, out_right_y, out_right_z, out_upax_x, out_upax_y,
                   out_upax_z, out_back_x, out_back_y, out_back_z};
        g.move = '{out_move_x, out_move_y, out_move_z};
        views.check_view(g);
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 16);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else if (!sending_done || views.pending.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_look_at_view_matrix failed");
      $finish;
    end
  end

  initial begin
    camera_t c;
    rst_n = 0; in_valid = 0; out_stall = 0; calm = 0; sending_done = 0;
    idle_cycles = 0;
    {in_pos_x, in_pos_y, in_pos_z, in_tgt_x, in_tgt_y, in_tgt_z} = '0;
    {in_upv_x, in_upv_y, in_upv_z} = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: plain view, zero lengths, parallel up, saturation, extremes
    cams.push_back(make_cam(0, 0, 32'sh5_0000, 0, 0, 0, 0, 32'sh1_0000, 0));
    cams.push_back(make_cam(1, 2, 3, 1, 2, 3, 0, 32'sh1_0000, 0));      // P equals T
    cams.push_back(make_cam(0, 0, 32'sh1_0000, 0, 0, 0, 0, 0, 0));      // zero up
    cams.push_back(make_cam(0, 0, 32'sh1_0000, 0, 0, 0, 0, 0, 32'sh7)); // up parallel
    cams.push_back(make_cam(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                            32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                            32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000));
    cams.push_back(make_cam(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0,
                            32'sh8000_0000, 0, 32'sh7fff_ffff));
    cams.push_back(make_cam(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                            32'sh8000_0000, 0, 1, 1, -1, 1));
    cams.push_back(make_cam(-1, -1, -1, 0, 0, 0, -1, 0, 0));
    cams.push_back(make_cam(32'sh0003_0000, 32'shffff_0000, 32'sh0002_0000,
                            0, 32'sh1_0000, 0, 32'sh1_0000, 32'sh1_0000, 0));
    cams.push_back(make_cam(-32'sh7fff_ffff, 32'sh7fff_ffff, 5,
                            32'sh7fff_ffff, -32'sh7fff_ffff, 5, 0, 0, 1));
    foreach (cams[i]) send_camera(cams[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 900);
      for (int i = 0; i < 3; i++) begin
        c.pos[i] = pick(); c.tgt[i] = pick(); c.upv[i] = pick();
      end
      if ($urandom_range(0, 49) == 0) c.tgt = c.pos;
      if ($urandom_range(0, 49) == 0) c.upv = '{0, 0, 0};
      send_camera(c);
    end
    calm = 0;
    in_valid <= 0;
    sending_done = 1;

    while (views.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (views.mismatches == 0 && views.pending.size() == 0)
      $display("tb_look_at_view_matrix passed");
    else
      $display("tb_look_at_view_matrix failed");
    $finish;
  end

endmodule
